FILE: rtl/core/rpd_pkg.sv
// types, codes and the crc byte update shared by the packet deframer
// no dependencies
`default_nettype none

package rpd_pkg;

  localparam logic [7:0]  PREAMBLE_RESET = 8'hAA;
  localparam logic [7:0]  SYNC_RESET     = 8'hAB;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'h8408;
  localparam logic [8:0]  LEN_OVERHEAD   = 9'd15;

  // configuration register indexes
  localparam logic CFG_PREAMBLE = 1'b0;
  localparam logic CFG_SYNC     = 1'b1;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_PREAMBLE = 3'd1;
  localparam logic [2:0] ST_SYNC     = 3'd2;
  localparam logic [2:0] ST_LENGTH   = 3'd3;
  localparam logic [2:0] ST_CRC      = 3'd4;
  localparam logic [2:0] ST_TRUNC    = 3'd5;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } rx_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [7:0]  byte_index;
    logic [2:0]  status;
    logic [7:0]  station;
    logic [7:0]  sequence_number;
    logic [31:0] time_stamp;
    logic [7:0]  total_length;
    logic [7:0]  info_length;
    logic [15:0] computed_crc;
    logic [15:0] trailer_crc;
  } result_t;

  // which captured field a byte lands in
  typedef enum logic [2:0] {
    CAP_NONE,
    CAP_LEN,
    CAP_STATION,
    CAP_SEQ,
    CAP_STAMP,
    CAP_INFO,
    CAP_TRAIL
  } cap_e;

  // what the back end emits for a byte
  typedef enum logic [1:0] {
    EM_NONE,
    EM_PAYLOAD,
    EM_STATUS,
    EM_CHECK
  } emit_e;

  typedef struct packed {
    logic       feed;
    cap_e       cap;
    emit_e      emit;
    logic [2:0] status;
    logic [7:0] data;
    logic [7:0] index;
  } cmd_t;

  // reflected crc-16, one byte lsb first
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] x;
    x = crc;
    for (int k = 0; k < 8; k++) begin
      if (x[0] ^ b[k]) begin
        x = (x >> 1) ^ CRC_POLY;
      end else begin
        x = x >> 1;
      end
    end
    return x;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/radio_packet_deframer_crc16.sv
// top level of the radio packet deframer with crc-16 check
// depends on rpd_pkg, rpd_front, rpd_queue, rpd_back
//
//   channel  | direction | handshake                 | beat
//   ---------+-----------+---------------------------+---------------------------
//   input    | in        | in_valid_i / in_stall_o   | rx_item_t: byte, frame end
//   result   | out       | out_valid_o / out_stall_i | result_t: payload or status
//   config   | in        | cfg_we_i                  | cfg_index_i, cfg_wdata_i
//
// one byte per cycle unless stalled; each byte's result is registered after the queue
// the crc advances a whole byte at a time inside the back end
// a two-entry command queue and the result register absorb output stalls;
// in_stall_o rises only when the queue is full
// reset is asynchronous and needs no clearing pass
`default_nettype none

module radio_packet_deframer_crc16 import rpd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_index_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output      logic       in_stall_o,
  input  wire rx_item_t   in_data_i,
  output      logic       out_valid_o,
  input  wire logic       out_stall_i,
  output      result_t    out_data_o
);

  logic accept, push, full, nonempty, pop;
  cmd_t push_cmd, pop_cmd;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  rpd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .item_i      (in_data_i),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  rpd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .nonempty_o (nonempty),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd)
  );

  rpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (nonempty),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/rpd_front.sv
// front end: tracks the frame position, checks preamble and sync, classifies bytes
// depends on rpd_pkg
`default_nettype none

module rpd_front import rpd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_index_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       accept_i,
  input  wire rx_item_t   item_i,
  output      logic       push_o,
  output      cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_TRAILER,
    PH_DISCARD
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] pos_q, pos_d;
  logic [7:0] info_q, info_d;
  logic [7:0] preamble_q, sync_q;

  logic [7:0] b;
  logic       fin;
  logic [7:0] pos_inc;

  assign b       = item_i.rx_byte;
  assign fin     = item_i.frame_end;
  assign pos_inc = pos_q + 8'd1;

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    info_d     = info_q;
    push_o     = 1'b0;
    cmd_o      = '0;
    cmd_o.cap  = CAP_NONE;
    cmd_o.emit = EM_NONE;
    cmd_o.data = b;
    unique case (phase_q)
      PH_HEADER: begin
        if (pos_q < 8'd4) begin
          if (b != preamble_q) begin
            push_o       = 1'b1;
            cmd_o.emit   = EM_STATUS;
            cmd_o.status = ST_PREAMBLE;
            phase_d      = fin ? PH_HEADER : PH_DISCARD;
            pos_d        = '0;
          end else if (fin) begin
            push_o       = 1'b1;
            cmd_o.emit   = EM_STATUS;
            cmd_o.status = ST_TRUNC;
            pos_d        = '0;
          end else begin
            pos_d = pos_inc;
          end
        end else begin
          push_o     = 1'b1;
          cmd_o.feed = 1'b1;
          priority if (pos_q == 8'd4) begin
            cmd_o.cap = CAP_LEN;
          end else if (pos_q == 8'd5) begin
            cmd_o.cap = CAP_NONE;
          end else if (pos_q == 8'd6) begin
            cmd_o.cap = CAP_STATION;
          end else if (pos_q == 8'd7) begin
            cmd_o.cap = CAP_SEQ;
          end else if (pos_q <= 8'd11) begin
            cmd_o.cap = CAP_STAMP;
          end else begin
            cmd_o.cap = CAP_INFO;
          end
          if (pos_q == 8'd5 && b != sync_q) begin
            cmd_o.emit   = EM_STATUS;
            cmd_o.status = ST_SYNC;
            phase_d      = fin ? PH_HEADER : PH_DISCARD;
            pos_d        = '0;
          end else if (fin) begin
            cmd_o.emit   = EM_STATUS;
            cmd_o.status = ST_TRUNC;
            phase_d      = PH_HEADER;
            pos_d        = '0;
          end else if (pos_q >= 8'd12) begin
            info_d  = b;
            pos_d   = '0;
            phase_d = (b != 8'd0) ? PH_PAYLOAD : PH_TRAILER;
          end else begin
            pos_d = pos_inc;
          end
        end
      end
      PH_PAYLOAD: begin
        push_o     = 1'b1;
        cmd_o.feed = 1'b1;
        if (fin) begin
          cmd_o.emit   = EM_STATUS;
          cmd_o.status = ST_TRUNC;
          phase_d      = PH_HEADER;
          pos_d        = '0;
        end else begin
          cmd_o.emit  = EM_PAYLOAD;
          cmd_o.index = pos_q;
          if (pos_inc >= info_q) begin
            pos_d   = '0;
            phase_d = PH_TRAILER;
          end else begin
            pos_d = pos_inc;
          end
        end
      end
      PH_TRAILER: begin
        push_o = 1'b1;
        if (pos_q == 8'd0) begin
          cmd_o.cap = CAP_TRAIL;
          if (fin) begin
            cmd_o.emit   = EM_STATUS;
            cmd_o.status = ST_TRUNC;
            phase_d      = PH_HEADER;
            pos_d        = '0;
          end else begin
            pos_d = 8'd1;
          end
        end else begin
          cmd_o.emit = EM_CHECK;
          phase_d    = fin ? PH_HEADER : PH_DISCARD;
          pos_d      = '0;
        end
      end
      PH_DISCARD: begin
        if (fin) begin
          phase_d = PH_HEADER;
          pos_d   = '0;
        end
      end
      default: begin
        phase_d = PH_HEADER;
        pos_d   = '0;
      end
    endcase
    if (!accept_i) begin
      push_o  = 1'b0;
      phase_d = phase_q;
      pos_d   = pos_q;
      info_d  = info_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      pos_q      <= '0;
      info_q     <= '0;
      preamble_q <= PREAMBLE_RESET;
      sync_q     <= SYNC_RESET;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      info_q  <= info_d;
      if (cfg_we_i && cfg_index_i == CFG_PREAMBLE) begin
        preamble_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_index_i == CFG_SYNC) begin
        sync_q <= cfg_wdata_i;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rpd_queue.sv
// two-entry command queue between front and back end
// depends on rpd_pkg
`default_nettype none

module rpd_queue import rpd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_cmd_i,
  output      logic full_o,
  output      logic nonempty_o,
  input  wire logic pop_i,
  output      cmd_t pop_cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] count_q;

  assign full_o     = (count_q == 2'd2);
  assign nonempty_o = (count_q != 2'd0);
  assign pop_cmd_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rpd_back.sv
// back end: crc update, field capture and result register
// depends on rpd_pkg
`default_nettype none

module rpd_back import rpd_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    cmd_valid_i,
  input  wire cmd_t    cmd_i,
  output      logic    pop_o,
  output      logic    out_valid_o,
  input  wire logic    out_stall_i,
  output      result_t out_data_o
);

  logic [15:0] crc_q, crc_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  station_q, station_d;
  logic [7:0]  seq_q, seq_d;
  logic [31:0] stamp_q, stamp_d;
  logic [7:0]  info_q, info_d;
  logic [7:0]  trail_q, trail_d;
  logic        out_valid_q;
  result_t     out_q, res_d;
  logic        out_free, closes;
  logic [15:0] comp, recv;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign pop_o       = cmd_valid_i && (cmd_i.emit == EM_NONE || out_free);
  assign closes      = (cmd_i.emit == EM_STATUS) || (cmd_i.emit == EM_CHECK);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign comp = ~crc_q;
  assign recv = {trail_q, cmd_i.data};

  always_comb begin
    crc_d     = cmd_i.feed ? crc_byte(crc_q, cmd_i.data) : crc_q;
    len_d     = (cmd_i.cap == CAP_LEN)     ? cmd_i.data : len_q;
    station_d = (cmd_i.cap == CAP_STATION) ? cmd_i.data : station_q;
    seq_d     = (cmd_i.cap == CAP_SEQ)     ? cmd_i.data : seq_q;
    stamp_d   = (cmd_i.cap == CAP_STAMP)   ? {stamp_q[23:0], cmd_i.data} : stamp_q;
    info_d    = (cmd_i.cap == CAP_INFO)    ? cmd_i.data : info_q;
    trail_d   = (cmd_i.cap == CAP_TRAIL)   ? cmd_i.data : trail_q;

    res_d = '0;
    if (cmd_i.emit == EM_PAYLOAD) begin
      res_d.kind         = KIND_PAYLOAD;
      res_d.payload_byte = cmd_i.data;
      res_d.byte_index   = cmd_i.index;
    end else begin
      res_d.kind            = KIND_STATUS;
      res_d.status          = cmd_i.status;
      res_d.station         = station_d;
      res_d.sequence_number = seq_d;
      res_d.time_stamp      = stamp_d;
      res_d.total_length    = len_d;
      res_d.info_length     = info_d;
      if (cmd_i.emit == EM_CHECK) begin
        res_d.computed_crc = comp;
        res_d.trailer_crc  = recv;
        // length rule is checked in 9 bits so that it cannot wrap
        if ({1'b0, len_q} != ({1'b0, info_q} + LEN_OVERHEAD)) begin
          res_d.status = ST_LENGTH;
        end else if (comp != recv) begin
          res_d.status = ST_CRC;
        end else begin
          res_d.status = ST_OK;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && cmd_i.emit != EM_NONE) begin
      out_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      crc_q       <= CRC_INIT;
      len_q       <= '0;
      station_q   <= '0;
      seq_q       <= '0;
      stamp_q     <= '0;
      info_q      <= '0;
      trail_q     <= '0;
    end else begin
      if (out_free) begin
        out_valid_q <= pop_o && cmd_i.emit != EM_NONE;
      end
      if (pop_o) begin
        // a status closes the frame: nothing captured is read again before a new one
        if (closes) begin
          crc_q     <= CRC_INIT;
          len_q     <= '0;
          station_q <= '0;
          seq_q     <= '0;
          stamp_q   <= '0;
          info_q    <= '0;
          trail_q   <= '0;
        end else begin
          crc_q     <= crc_d;
          len_q     <= len_d;
          station_q <= station_d;
          seq_q     <= seq_d;
          stamp_q   <= stamp_d;
          info_q    <= info_d;
          trail_q   <= trail_d;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rpd_checker.sv
// port-level checks on the deframer results, bound to the top level
// depends on rpd_pkg
`default_nettype none

module rpd_checker import rpd_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire result_t    out_data_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_PAYLOAD |->
      out_data_o.status == ST_OK && out_data_o.computed_crc == 16'd0 &&
      out_data_o.trailer_crc == 16'd0)
    else $error("payload beat carries status fields");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_STATUS |->
      out_data_o.payload_byte == 8'd0 && out_data_o.byte_index == 8'd0)
    else $error("status beat carries payload fields");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_STATUS |->
      out_data_o.status <= ST_TRUNC)
    else $error("undefined status code");

  // crcs are reported only once the trailer is complete
  a_crc_only_on_trailer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_STATUS &&
      (out_data_o.status == ST_PREAMBLE || out_data_o.status == ST_SYNC ||
       out_data_o.status == ST_TRUNC) |->
      out_data_o.computed_crc == 16'd0 && out_data_o.trailer_crc == 16'd0)
    else $error("crc reported on an unfinished frame");

endmodule

bind radio_packet_deframer_crc16 rpd_checker u_rpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
